// File: rtl/core/adne_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adne_pkg
// shared constants, types and helpers of the advertising-data name extractor
// ----------------------------------------------------------------------------
package adne_pkg;

	localparam int NAME_MAX  = 28;
	localparam int LEN_W     = 5;
	localparam int BYTE_W    = 8;
	// name buffers: staging, kept, two queued reports, one streaming
	localparam int NBANK     = 5;
	localparam int BANK_W    = 3;
	localparam int ADDR_W    = BANK_W + LEN_W;
	localparam int MEM_DEPTH = NBANK * (1 << LEN_W);

	localparam logic [BYTE_W-1:0] TYPE_SHORT_NAME = 8'h08;
	localparam logic [BYTE_W-1:0] TYPE_FULL_NAME  = 8'h09;

	typedef logic [NBANK-1:0] bank_mask_t;

	// finished report handed from the parser to the streamer
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [LEN_W-1:0]  len;
	} handoff_t;

	// name buffer write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_t;

	function automatic bank_mask_t bank_onehot(input logic [BANK_W-1:0] bank);
		bank_onehot = bank_mask_t'(1) << bank;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/adne_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adne channel interfaces
// valid/ready channels for advertising bytes in and name bytes out
// ----------------------------------------------------------------------------
interface adne_in_if;
	logic                       valid;
	logic                       ready;
	logic [adne_pkg::BYTE_W-1:0] ad_byte;
	logic                       report_end;

	modport source (output valid, ad_byte, report_end, input ready);
	modport sink   (input valid, ad_byte, report_end, output ready);
endinterface

interface adne_out_if;
	logic                       valid;
	logic                       ready;
	logic [adne_pkg::BYTE_W-1:0] name_char;
	logic [adne_pkg::LEN_W-1:0]  name_length;
	logic                       last_char;

	modport source (output valid, name_char, name_length, last_char, input ready);
	modport sink   (input valid, name_char, name_length, last_char, output ready);
endinterface
`default_nettype wire

// File: rtl/core/adne_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adne_front
// accepts advertising bytes, walks length/type/data structures, stages names
// ----------------------------------------------------------------------------
module adne_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	adne_in_if.sink                       in_ch,
	input  wire logic                     cfg_we,
	input  wire logic [adne_pkg::LEN_W-1:0] cfg_wdata,
	input  wire logic                     q_full,
	input  wire adne_pkg::bank_mask_t     busy_mask,
	output adne_pkg::wr_t                 wr,
	output logic                          push,
	output adne_pkg::handoff_t            hand
);
	import adne_pkg::*;

	typedef enum logic [2:0] {
		PH_LEN  = 3'b001,
		PH_TYPE = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_FULL  = 2'd2
	} kind_t;

	phase_t              phase_q, phase_d;
	kind_t               kind_q, kind_d;
	logic [BYTE_W-1:0]   left_q, left_d, left_dec;
	logic                stop_q, stop_d;
	logic [LEN_W-1:0]    slen_q, slen_d, klen_q, klen_d;
	logic [BANK_W-1:0]   sbank_q, sbank_d, kbank_q, kbank_d, alloc;
	logic [LEN_W-1:0]    limit_q, eff_limit;
	logic                acc, finish, wr_en_c;
	bank_mask_t          in_use;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign eff_limit   = (limit_q > LEN_W'(NAME_MAX)) ? LEN_W'(NAME_MAX) : limit_q;
	assign left_dec    = left_q - BYTE_W'(1);
	assign in_use      = bank_onehot(sbank_q) | bank_onehot(kbank_q) | busy_mask;

	// lowest free buffer becomes the next kept buffer at report end
	always_comb begin
		alloc = '0;
		for (int i = NBANK - 1; i >= 0; i--) begin
			if (!in_use[i]) begin
				alloc = BANK_W'(i);
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		left_d  = left_q;
		stop_d  = stop_q;
		slen_d  = slen_q;
		klen_d  = klen_q;
		sbank_d = sbank_q;
		kbank_d = kbank_q;
		finish  = 1'b0;
		wr_en_c = 1'b0;
		if (!stop_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (in_ch.ad_byte == '0) begin
						stop_d = 1'b1;
					end else begin
						left_d  = in_ch.ad_byte;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					left_d = left_dec;
					if (in_ch.ad_byte == TYPE_SHORT_NAME) begin
						kind_d = KIND_SHORT;
					end else if (in_ch.ad_byte == TYPE_FULL_NAME) begin
						kind_d = KIND_FULL;
					end else begin
						kind_d = KIND_NONE;
					end
					slen_d = '0;
					if (left_dec == '0) begin
						finish = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					if (kind_q != KIND_NONE && slen_q < eff_limit) begin
						wr_en_c = 1'b1;
						slen_d  = slen_q + LEN_W'(1);
					end
					left_d = left_dec;
					if (left_dec == '0) begin
						finish = 1'b1;
					end
				end
				default: begin
					phase_d = PH_LEN;
				end
			endcase
			// a finished name swaps staging and kept buffers instead of copying
			if (finish) begin
				if (kind_d != KIND_NONE) begin
					klen_d  = slen_d;
					kbank_d = sbank_q;
					sbank_d = kbank_q;
					if (kind_d == KIND_FULL) begin
						stop_d = 1'b1;
					end
				end
				kind_d  = KIND_NONE;
				phase_d = PH_LEN;
			end
		end
		hand.bank = kbank_d;
		hand.len  = klen_d;
		if (in_ch.report_end) begin
			klen_d  = '0;
			slen_d  = '0;
			left_d  = '0;
			phase_d = PH_LEN;
			kind_d  = KIND_NONE;
			stop_d  = 1'b0;
			kbank_d = alloc;
		end
	end

	assign push    = acc && in_ch.report_end;
	assign wr.en   = acc && wr_en_c;
	assign wr.addr = {sbank_q, slen_q};
	assign wr.data = in_ch.ad_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			kind_q  <= KIND_NONE;
			left_q  <= '0;
			stop_q  <= 1'b0;
			slen_q  <= '0;
			klen_q  <= '0;
			sbank_q <= BANK_W'(0);
			kbank_q <= BANK_W'(1);
		end else if (acc) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			left_q  <= left_d;
			stop_q  <= stop_d;
			slen_q  <= slen_d;
			klen_q  <= klen_d;
			sbank_q <= sbank_d;
			kbank_q <= kbank_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LEN_W'(NAME_MAX);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

`ifndef SYNTH
	a_banks_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		sbank_q != kbank_q)
		else $error("staging and kept buffers coincide");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_hand_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (busy_mask & bank_onehot(hand.bank)) == '0)
		else $error("handed buffer still queued or streaming");
`endif
endmodule
`default_nettype wire

// File: rtl/core/adne_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adne_queue
// two-entry queue of finished reports between parser and streamer
// ----------------------------------------------------------------------------
module adne_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire adne_pkg::handoff_t    push_data,
	input  wire logic                  pop,
	output adne_pkg::handoff_t         head,
	output logic                       head_valid,
	output logic                       full,
	output adne_pkg::bank_mask_t       used_mask
);
	import adne_pkg::*;

	handoff_t entry_q [2];
	logic [1:0] vld_q;
	logic       wr_ptr_q, rd_ptr_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = vld_q[rd_ptr_q];
	assign full       = &vld_q;

	always_comb begin
		used_mask = '0;
		for (int i = 0; i < 2; i++) begin
			if (vld_q[i]) begin
				used_mask = used_mask | bank_onehot(entry_q[i].bank);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q        <= !wr_ptr_q;
			end
			if (pop) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q        <= !rd_ptr_q;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/adne_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adne_back
// name buffer memory and streamer that sends one name byte per transaction
// ----------------------------------------------------------------------------
module adne_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire adne_pkg::wr_t         wr,
	input  wire logic                  q_valid,
	input  wire adne_pkg::handoff_t    q_head,
	output logic                       pop,
	output adne_pkg::bank_mask_t       cur_mask,
	adne_out_if.source                 out_ch
);
	import adne_pkg::*;

	logic [BYTE_W-1:0] mem [MEM_DEPTH];

	logic              cur_valid_q;
	logic [BANK_W-1:0] cur_bank_q;
	logic [LEN_W-1:0]  cur_len_q, cur_idx_q, idx_inc;
	logic              issue, last, move_s1;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              last_s1;

	logic              out_valid_q;

	assign move_s1 = valid_s1 && (!out_valid_q || out_ch.ready);
	assign issue   = cur_valid_q && (!valid_s1 || move_s1);
	assign idx_inc = cur_idx_q + LEN_W'(1);
	// an empty name still gives one result
	assign last    = (cur_len_q == '0) || (idx_inc == cur_len_q);
	assign pop     = q_valid && (!cur_valid_q || (issue && last));
	assign cur_mask = cur_valid_q ? bank_onehot(cur_bank_q) : '0;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1 <= mem[{cur_bank_q, cur_idx_q}];
			len_s1  <= cur_len_q;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_bank_q  <= '0;
			cur_len_q   <= '0;
			cur_idx_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				cur_bank_q  <= q_head.bank;
				cur_len_q   <= q_head.len;
				cur_idx_q   <= '0;
			end else if (issue && last) begin
				cur_valid_q <= 1'b0;
			end else if (issue) begin
				cur_idx_q <= idx_inc;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (!out_valid_q || out_ch.ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_ch.name_char   <= (len_s1 == '0) ? '0 : data_s1;
			out_ch.name_length <= len_s1;
			out_ch.last_char   <= last_s1;
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTH
	a_no_write_streaming: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && cur_valid_q |-> wr.addr[ADDR_W-1 -: BANK_W] != cur_bank_q)
		else $error("write into the buffer being streamed");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_len_q == '0 || cur_idx_q < cur_len_q))
		else $error("stream index past name length");
`endif
endmodule
`default_nettype wire

// File: rtl/core/adne_data_name_extractor_top.sv
`default_nettype none
// names leave via queue entry, current-name registers, read stage, output register
// throughput: one advertising byte per cycle; names stream one byte per cycle
// while out_ch is ready; intake stalls only while two finished reports are queued
// reset: arst_n clears parser, queue and streamer control at once; name limit
// returns to 28; name buffers are not cleared and need no sweep
// ----------------------------------------------------------------------------
// adv_data_name_extractor_top
// local-name extractor for advertising reports: parser front end, report
// queue and name streamer back end
// ----------------------------------------------------------------------------
module adv_data_name_extractor_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	adne_in_if.sink                         in_ch,
	adne_out_if.source                      out_ch,
	input  wire logic                       cfg_we,
	input  wire logic [adne_pkg::LEN_W-1:0] cfg_wdata
);
	import adne_pkg::*;

	// parser to memory: name bytes written into the staging buffer
	wr_t        wr;
	// parser to queue: one transaction per finished report
	logic       push;
	handoff_t   hand;
	// queue to streamer
	logic       pop;
	handoff_t   q_head;
	logic       q_valid;
	logic       q_full;
	// buffers held downstream, kept away from the parser's allocator
	bank_mask_t q_used, cur_mask, busy_mask;

	assign busy_mask = q_used | cur_mask;

	// front: accepts bytes, tracks structures, swaps staging and kept buffers
	adne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.busy_mask (busy_mask),
		.wr        (wr),
		.push      (push),
		.hand      (hand)
	);

	// short queue decouples report intake from name streaming
	adne_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (hand),
		.pop        (pop),
		.head       (q_head),
		.head_valid (q_valid),
		.full       (q_full),
		.used_mask  (q_used)
	);

	// back: reads the handed buffer and sends one byte per transaction
	adne_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.cur_mask (cur_mask),
		.out_ch   (out_ch)
	);
endmodule
`default_nettype wire
